FILE: hw/rtl/sfp_pkg.sv
// Shared types and constants of the serial frame parser.
// No dependencies; imported by every module of the block.
package sfp_pkg;

  localparam int MAX_PAYLOAD_DEF = 64;
  localparam int RX_LIMIT_DEF    = 128;

  localparam logic [7:0] START_MARKER_RST = 8'hAA;
  localparam logic [7:0] END_MARKER_RST   = 8'h55;

  // configuration register indexes
  localparam logic [7:0] CFG_START_MARKER = 8'd0;
  localparam logic [7:0] CFG_END_MARKER   = 8'd1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_CSUM = 2'd1,
    ST_END  = 2'd2,
    ST_LONG = 2'd3
  } status_t;

  // one frame outcome handed from the parser to the result buffer
  typedef struct packed {
    logic       load;
    logic       has_data;
    status_t    status;
    logic [7:0] command;
    logic [7:0] length;
  } result_req_t;

endpackage

FILE: hw/rtl/sfp_result_buf.sv
// Ping-pong payload memory and result output register of the frame parser.
// Depends on sfp_pkg.
module sfp_result_buf #(
  parameter int MAX_PAYLOAD = sfp_pkg::MAX_PAYLOAD_DEF,
  parameter int IDXW        = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  sfp_pkg::result_req_t req,
  input  logic                wr_en,
  input  logic [IDXW-1:0]     wr_idx,
  input  logic [7:0]          wr_data,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          command,
  output logic [7:0]          payload_length,
  output logic [7:0]          payload_byte,
  output logic [5:0]          byte_index,
  output logic                has_data,
  output logic                last,
  output logic [1:0]          status
);
  import sfp_pkg::*;

  localparam int DEPTH = 2 * (2 ** IDXW);

  logic [7:0]      mem [DEPTH];
  logic [7:0]      rd_data;
  logic [IDXW:0]   rd_addr;
  logic            wr_bank;
  logic            o_bank;
  logic [IDXW-1:0] o_idx;
  logic [8:0]      idx_plus2;
  logic            advance;
  status_t         o_status;

  assign free    = !out_valid || (!out_stall && last);
  assign advance = out_valid && !out_stall && !last;
  assign idx_plus2 = 9'(o_idx) + 9'd2;

  // read address tracks the index the output register will show next cycle
  always_comb begin
    if (req.load && req.has_data) begin
      rd_addr = {wr_bank, {IDXW{1'b0}}};
    end else if (advance) begin
      rd_addr = {o_bank, o_idx + 1'b1};
    end else begin
      rd_addr = {o_bank, o_idx};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{wr_bank, wr_idx}] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      wr_bank   <= 1'b0;
      last      <= 1'b1;
    end else if (req.load) begin
      out_valid      <= 1'b1;
      command        <= req.command;
      payload_length <= req.length;
      has_data       <= req.has_data;
      o_status       <= req.status;
      o_idx          <= '0;
      if (req.has_data) begin
        o_bank  <= wr_bank;
        wr_bank <= ~wr_bank;
        last    <= (req.length == 8'd1);
      end else begin
        last <= 1'b1;
      end
    end else if (out_valid && !out_stall) begin
      if (last) begin
        out_valid <= 1'b0;
      end else begin
        o_idx <= o_idx + 1'b1;
        last  <= (idx_plus2 == {1'b0, payload_length});
      end
    end
  end

  assign payload_byte = has_data ? rd_data : 8'd0;
  assign byte_index   = 6'(o_idx);
  assign status       = o_status;

endmodule

FILE: hw/rtl/serial_frame_parser_unit.sv
// Top level of the serial frame parser: frame tracking and configuration.
// Depends on sfp_pkg and sfp_result_buf.
//
// Usage:
//   Input channel (in_valid/in_stall, rx_byte) takes one link byte per cycle.
//   Bytes are matched against start_marker while hunting, then read as
//   command, length, payload, XOR checksum and end marker.
//   Output channel (out_valid/out_stall) gives one result per payload byte
//   of a good frame, last set on the final one, or a single result for an
//   empty frame or an error (status 1 checksum, 2 end marker, 3 too long).
//   First result is registered in the cycle after the end marker (or the
//   oversize length byte) is accepted; payload drains at one result a cycle.
//   Throughput: one input byte per cycle. Payload goes to a two-bank memory,
//   so the next frame fills one bank while the other drains. in_stall rises
//   only on a frame-ending byte while the previous frame is still draining.
//   Receiver stall holds the output register and, through that, the drain.
//   Config port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
//   index 0 start marker, 1 end marker, others ignored.
//   Reset (rst, synchronous): hunting, markers 0xAA/0x55, no result pending.
//   No memory clearing is needed; only bytes of the current frame are read.
module serial_frame_parser_unit #(
  parameter int MAX_PAYLOAD = sfp_pkg::MAX_PAYLOAD_DEF,
  parameter int RX_LIMIT    = sfp_pkg::RX_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] command,
  output logic [7:0] payload_length,
  output logic [7:0] payload_byte,
  output logic [5:0] byte_index,
  output logic       has_data,
  output logic       last,
  output logic [1:0] status
);
  import sfp_pkg::*;

  localparam int IDXW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW   = $clog2(RX_LIMIT);

  logic [7:0]    start_marker;
  logic [7:0]    end_marker;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [7:0]    frame_command, frame_command_next;
  logic [7:0]    frame_length, frame_length_next;
  logic [7:0]    running_checksum, running_checksum_next;
  logic          checksum_match, checksum_match_next;

  logic          accept;
  logic          result_pos;
  logic          buf_free;
  logic [8:0]    c9, len9, pay_off;
  logic [CW:0]   count_inc;
  logic          wr_en;
  logic [IDXW-1:0] wr_idx;
  result_req_t   req;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RST;
      end_marker   <= END_MARKER_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_START_MARKER) begin
        start_marker <= cfg_data;
      end else if (cfg_index == CFG_END_MARKER) begin
        end_marker <= cfg_data;
      end
    end
  end

  assign c9        = 9'(byte_count);
  assign len9      = {1'b0, frame_length};
  assign pay_off   = c9 - 9'd3;
  assign wr_idx    = pay_off[IDXW-1:0];
  assign count_inc = {1'b0, byte_count} + 1'b1;

  // bytes that produce a result wait until the output side can take it
  assign result_pos = ((c9 == 9'd2) && (9'(rx_byte) > 9'(MAX_PAYLOAD))) ||
                      (c9 == len9 + 9'd4);
  assign in_stall   = result_pos && !buf_free;
  assign accept     = in_valid && !in_stall;

  always_comb begin
    byte_count_next       = byte_count;
    frame_command_next    = frame_command;
    frame_length_next     = frame_length;
    running_checksum_next = running_checksum;
    checksum_match_next   = checksum_match;
    wr_en                 = 1'b0;
    req.load              = 1'b0;
    req.has_data          = 1'b0;
    req.status            = ST_OK;
    req.command           = frame_command;
    req.length            = frame_length;
    if (accept) begin
      byte_count_next = (count_inc >= (CW+1)'(RX_LIMIT)) ? '0 : count_inc[CW-1:0];
      if (c9 == 9'd0) begin
        if (rx_byte != start_marker) begin
          byte_count_next = byte_count;
        end
      end else if (c9 == 9'd1) begin
        frame_command_next    = rx_byte;
        running_checksum_next = rx_byte;
        req.command           = rx_byte;
      end else if (c9 == 9'd2) begin
        frame_length_next     = rx_byte;
        running_checksum_next = running_checksum ^ rx_byte;
        if (9'(rx_byte) > 9'(MAX_PAYLOAD)) begin
          req.load   = 1'b1;
          req.status = ST_LONG;
          req.length = rx_byte;
        end
      end else if (c9 < len9 + 9'd3) begin
        wr_en                 = 1'b1;
        running_checksum_next = running_checksum ^ rx_byte;
      end else if (c9 == len9 + 9'd3) begin
        checksum_match_next = (rx_byte == running_checksum);
      end else begin
        req.load = 1'b1;
        if (!checksum_match) begin
          req.status = ST_CSUM;
        end else if (rx_byte != end_marker) begin
          req.status = ST_END;
        end else begin
          req.has_data = (frame_length != 8'd0);
        end
      end
      if (req.load) begin
        byte_count_next = '0;
      end
      if (byte_count_next == '0) begin
        running_checksum_next = 8'd0;
        checksum_match_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= '0;
      frame_command    <= 8'd0;
      frame_length     <= 8'd0;
      running_checksum <= 8'd0;
      checksum_match   <= 1'b0;
    end else begin
      byte_count       <= byte_count_next;
      frame_command    <= frame_command_next;
      frame_length     <= frame_length_next;
      running_checksum <= running_checksum_next;
      checksum_match   <= checksum_match_next;
    end
  end

  sfp_result_buf #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .IDXW       (IDXW)
  ) u_buf (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .wr_en         (wr_en),
    .wr_idx        (wr_idx),
    .wr_data       (rx_byte),
    .free          (buf_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .command       (command),
    .payload_length(payload_length),
    .payload_byte  (payload_byte),
    .byte_index    (byte_index),
    .has_data      (has_data),
    .last          (last),
    .status        (status)
  );

endmodule

FILE: hw/rtl/sfp_checker.sv
// Port-level checks of the serial frame parser, bound to the top level.
// Depends on sfp_pkg for status codes.
module sfp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] payload_byte,
  input logic [5:0] byte_index,
  input logic       has_data,
  input logic       last,
  input logic [1:0] status
);
  import sfp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(payload_byte) && $stable(last))
    else $error("stalled output transaction changed");

  a_nodata_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_data |-> last && payload_byte == 8'd0 && byte_index == 6'd0)
    else $error("result without data is not a lone final result");

  a_err_nodata: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> !has_data)
    else $error("error result carries data");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && has_data && !last |=>
      out_valid && has_data && byte_index == $past(byte_index) + 6'd1)
    else $error("payload run skipped or repeated a byte");

endmodule

bind serial_frame_parser_unit sfp_checker u_sfp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .payload_byte(payload_byte),
  .byte_index  (byte_index),
  .has_data    (has_data),
  .last        (last),
  .status      (status)
);
